/* hdl/tdfs_pkg.sv */
// Shared types, codes and helper functions for the time/date field setter.
// No dependencies; every other file in hdl/ imports this package.
package tdfs_pkg;

  // Action codes carried in the input word.
  typedef enum logic [2:0] {
    ACT_REFRESH = 3'd0,
    ACT_NEXT    = 3'd1,
    ACT_DEC     = 3'd2,
    ACT_INC     = 3'd3,
    ACT_LOAD    = 3'd4
  } action_t;

  // Field selector codes.
  localparam logic [1:0] SEL_FIRST  = 2'd0;
  localparam logic [1:0] SEL_SECOND = 2'd1;
  localparam logic [1:0] SEL_THIRD  = 2'd2;

  // Field limits.
  localparam logic [5:0] HOUR_MAX   = 6'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;
  localparam logic [5:0] MONTH_MAX  = 6'd12;
  localparam logic [5:0] YEAR_MAX   = 6'd40;
  localparam logic [5:0] ZERO_MIN   = 6'd0;
  localparam logic [5:0] ONE_MIN    = 6'd1;

  localparam logic [3:0] BLANK_CODE = 4'd15;

  typedef struct packed {
    logic [2:0] action;
    logic       blink_event;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
    logic [4:0] load_day;
    logic [3:0] load_month;
    logic [5:0] load_year;
  } in_word_t;

  typedef struct packed {
    logic [3:0] digit_0;
    logic [3:0] digit_1;
    logic [3:0] digit_2;
    logic [3:0] digit_3;
    logic [3:0] digit_4;
    logic [3:0] digit_5;
  } out_word_t;

  // What the display formatter needs from the state holder.
  typedef struct packed {
    logic [2:0][5:0] field;
    logic [1:0]      sel;
    logic            blink;
  } view_t;

  // Day limit of the month; years 0..63 are leap exactly when a multiple of 4.
  function automatic logic [5:0] month_days(input logic [3:0] month, input logic [5:0] year);
    logic [5:0] days;
    days = 6'd31;
    if (month == 4'd2) begin
      days = (year[1:0] == 2'b00) ? 6'd29 : 6'd28;
    end else if (month == 4'd4 || month == 4'd6 || month == 4'd9 || month == 4'd11) begin
      days = 6'd30;
    end
    return days;
  endfunction

  // Step v within lo..hi with wrap; a value above hi holds on up, one below lo holds on down.
  function automatic logic [5:0] step_wrap(input logic [5:0] v, input logic [5:0] lo,
                                           input logic [5:0] hi, input logic up);
    logic [5:0] r;
    r = v;
    if (up) begin
      if (v < hi) r = v + 6'd1;
      else if (v == hi) r = lo;
    end else begin
      if (v > lo) r = v - 6'd1;
      else if (v == lo) r = hi;
    end
    return r;
  endfunction

  // Tens digit of a 6-bit value: (v * 13) >> 7 is exact for v below 69.
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [9:0] prod;
    prod = {4'd0, v} * 10'd13;
    return {1'b0, prod[9:7]};
  endfunction

  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [5:0] tens_x10;
    tens_x10 = {2'b00, tens_of(v)} * 6'd10;
    return 4'(v - tens_x10);
  endfunction

endpackage

/* hdl/tdfs_core.sv */
// State holder: time/date values, field selector and blink flag.
// Depends on tdfs_pkg; updates state on each processed word.
module tdfs_core
  import tdfs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  in_word_t item,
  input  logic     show_date,
  output view_t    view
);

  logic [4:0] hour_r, hour_nxt;
  logic [5:0] minute_r, minute_nxt;
  logic [5:0] second_r, second_nxt;
  logic [4:0] day_r, day_nxt;
  logic [3:0] month_r, month_nxt;
  logic [5:0] year_r, year_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic       blink_r, blink_nxt;
  logic       up;
  logic [5:0] day_lim;

  assign up      = (item.action == ACT_INC);
  assign day_lim = month_days(month_r, year_r);

  always_comb begin
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    day_nxt    = day_r;
    month_nxt  = month_r;
    year_nxt   = year_r;
    sel_nxt    = sel_r;
    blink_nxt  = blink_r;
    case (item.action)
      ACT_REFRESH: begin
        blink_nxt = blink_r ^ item.blink_event;
      end
      ACT_NEXT: begin
        sel_nxt = (sel_r == SEL_FIRST)  ? SEL_SECOND :
                  (sel_r == SEL_SECOND) ? SEL_THIRD  : SEL_FIRST;
      end
      ACT_DEC, ACT_INC: begin
        if (!show_date) begin
          case (sel_r)
            SEL_FIRST:  hour_nxt   = 5'(step_wrap({1'b0, hour_r}, ZERO_MIN, HOUR_MAX, up));
            SEL_SECOND: minute_nxt = step_wrap(minute_r, ZERO_MIN, MINSEC_MAX, up);
            SEL_THIRD:  second_nxt = step_wrap(second_r, ZERO_MIN, MINSEC_MAX, up);
            default: ;
          endcase
        end else begin
          case (sel_r)
            SEL_FIRST:  day_nxt   = 5'(step_wrap({1'b0, day_r}, ONE_MIN, day_lim, up));
            SEL_SECOND: month_nxt = 4'(step_wrap({2'b00, month_r}, ONE_MIN, MONTH_MAX, up));
            SEL_THIRD:  year_nxt  = step_wrap(year_r, ZERO_MIN, YEAR_MAX, up);
            default: ;
          endcase
        end
      end
      ACT_LOAD: begin
        hour_nxt   = item.load_hour;
        minute_nxt = item.load_minute;
        second_nxt = item.load_second;
        day_nxt    = item.load_day;
        month_nxt  = item.load_month;
        year_nxt   = item.load_year;
        sel_nxt    = SEL_FIRST;
        blink_nxt  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r   <= 5'd0;
      minute_r <= 6'd0;
      second_r <= 6'd0;
      day_r    <= 5'd1;
      month_r  <= 4'd1;
      year_r   <= 6'd0;
      sel_r    <= SEL_FIRST;
      blink_r  <= 1'b0;
    end else if (fire) begin
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
      day_r    <= day_nxt;
      month_r  <= month_nxt;
      year_r   <= year_nxt;
      sel_r    <= sel_nxt;
      blink_r  <= blink_nxt;
    end
  end

  // Blink as it stands after this refresh's toggle.
  always_comb begin
    view.sel   = sel_r;
    view.blink = blink_nxt;
    if (!show_date) begin
      view.field[0] = {1'b0, hour_r};
      view.field[1] = minute_r;
      view.field[2] = second_r;
    end else begin
      view.field[0] = {1'b0, day_r};
      view.field[1] = {2'b00, month_r};
      view.field[2] = year_r;
    end
  end

endmodule

/* hdl/tdfs_fmt.sv */
// Display formatter: three 6-bit fields to six decimal digits with blanking.
// Depends on tdfs_pkg (view_t, out_word_t, digit helpers).
module tdfs_fmt
  import tdfs_pkg::*;
(
  input  view_t     view,
  output out_word_t digits
);

  logic [2:0][3:0] tens;
  logic [2:0][3:0] ones;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (view.blink && (view.sel == 2'(k))) begin
        tens[k] = BLANK_CODE;
        ones[k] = BLANK_CODE;
      end else begin
        tens[k] = tens_of(view.field[k]);
        ones[k] = ones_of(view.field[k]);
      end
    end
  end

  assign digits.digit_0 = tens[0];
  assign digits.digit_1 = ones[0];
  assign digits.digit_2 = tens[1];
  assign digits.digit_3 = ones[1];
  assign digits.digit_4 = tens[2];
  assign digits.digit_5 = ones[2];

endmodule

/* hdl/time_date_field_setter.sv */
// Top level of the time/date field setter: input register, state, result register.
// Depends on tdfs_pkg, tdfs_core and tdfs_fmt.
//
// Button-driven clock and calendar setter for a six-digit display. Each input
// word carries one action: refresh, next field, decrement, increment or load.
// Only a refresh produces an output word: the three fields of the current mode
// (hour/minute/second when the mode bit is 0, day/month/year when it is 1) as six
// decimal digits, the selected pair shown as 15 (blank) while blink is on. A
// refresh with blink_event set toggles blink before the digits are formed; the
// 500 ms blink timer lives outside and drives blink_event. Edits wrap at each
// field's limits, the day limit follows the month, and February is 29 days in
// years that are multiples of four (year 0 included). Rate: one word per clock
// unless stalled. An accepted word sits in the input register, where the state
// update and the digit conversion (a multiply-by-13 reciprocal for the tens)
// happen in one pass, and a refresh's digits then land in the output register.
// The input keeps flowing while a finished output word waits; it stalls only
// when both registers are full and out_ready is low.
// Write the mode bit through cfg_we/cfg_wdata only while no word is in flight.
module time_date_field_setter
  import tdfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic      in_valid_r;
  in_word_t  in_word_r;
  logic      out_valid_r;
  out_word_t out_word_r;
  logic      show_date_r;
  logic      fire;
  logic      is_refresh;
  view_t     view;
  out_word_t digits;

  // Process the held word when the result slot is free or draining this cycle.
  assign fire       = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !in_valid_r || fire;
  assign is_refresh = (in_word_r.action == ACT_REFRESH);

  // Mode register: take the write directly.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      show_date_r <= 1'b0;
    end else if (cfg_we) begin
      show_date_r <= cfg_wdata;
    end
  end

  // Input register: hold the word until it is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_word;
    end
  end

  tdfs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (in_word_r),
    .show_date (show_date_r),
    .view      (view)
  );

  tdfs_fmt u_fmt (
    .view   (view),
    .digits (digits)
  );

  // Result register: load on a processed refresh, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && is_refresh) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_refresh) begin
      out_word_r <= digits;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef NO_ASSERTIONS
  // Input stalls only when both stages are full and the output is blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full pipeline");

  // A processed refresh always presents a result next cycle.
  a_refresh_result: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_refresh) |=> out_valid_r)
    else $error("refresh produced no result");

  // A non-refresh word never creates a result.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !is_refresh) |=> (out_valid_r == $past(out_valid_r && !out_ready)))
    else $error("result appeared for a non-refresh word");

  // A held result is never overwritten while it waits.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !fire)
    else $error("held result overwritten");
`endif

endmodule

/* dv/time_date_field_setter_checker.sv */
`timescale 1ns / 1ps
// Checker for time_date_field_setter: tracks the block state, predicts refresh digits, compares.
// Depends on tdfs_pkg for the word types, action codes, selector codes and field limits.
module time_date_field_setter_checker
  import tdfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_word_t    in_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_word_t   out_word,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  output int unsigned fault_count,
  output int unsigned digits_owed
);

  logic       show_date;
  logic [4:0] hour_q;
  logic [5:0] minute_q;
  logic [5:0] second_q;
  logic [4:0] day_q;
  logic [3:0] month_q;
  logic [5:0] year_q;
  logic [1:0] sel_q;
  logic       blink_q;

  out_word_t   digits_due [$];
  int unsigned faults = 0;

  // Gregorian rule on the raw year value.
  function automatic logic [5:0] day_limit(input logic [3:0] month, input logic [5:0] year);
    int unsigned yr;
    yr = year;
    if (month == 4'd2) begin
      return ((yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0))) ? 6'd29 : 6'd28;
    end
    if (month == 4'd4 || month == 4'd6 || month == 4'd9 || month == 4'd11) begin
      return 6'd30;
    end
    return 6'd31;
  endfunction

  function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [5:0] lo,
                                         input logic [5:0] hi);
    if (v < hi) return v + 6'd1;
    if (v == hi) return lo;
    return v;
  endfunction

  function automatic logic [5:0] wrap_down(input logic [5:0] v, input logic [5:0] lo,
                                           input logic [5:0] hi);
    if (v > lo) return v - 6'd1;
    if (v == lo) return hi;
    return v;
  endfunction

  function automatic void edit_selected(input logic up);
    logic [5:0] v;
    logic [5:0] lo;
    logic [5:0] hi;
    if (sel_q != SEL_FIRST && sel_q != SEL_SECOND && sel_q != SEL_THIRD) return;
    if (!show_date) begin
      v  = (sel_q == SEL_FIRST) ? {1'b0, hour_q} : (sel_q == SEL_SECOND) ? minute_q : second_q;
      lo = ZERO_MIN;
      hi = (sel_q == SEL_FIRST) ? HOUR_MAX : MINSEC_MAX;
    end else begin
      v  = (sel_q == SEL_FIRST) ? {1'b0, day_q} : (sel_q == SEL_SECOND) ? {2'b00, month_q} : year_q;
      lo = (sel_q == SEL_THIRD) ? ZERO_MIN : ONE_MIN;
      hi = (sel_q == SEL_FIRST) ? day_limit(month_q, year_q)
         : (sel_q == SEL_SECOND) ? MONTH_MAX : YEAR_MAX;
    end
    v = up ? wrap_up(v, lo, hi) : wrap_down(v, lo, hi);
    if (!show_date) begin
      if (sel_q == SEL_FIRST) hour_q = v[4:0];
      else if (sel_q == SEL_SECOND) minute_q = v;
      else second_q = v;
    end else begin
      if (sel_q == SEL_FIRST) day_q = v[4:0];
      else if (sel_q == SEL_SECOND) month_q = v[3:0];
      else year_q = v;
    end
  endfunction

  function automatic void take_word(input in_word_t w);
    logic [5:0] shown [3];
    out_word_t  exp_w;
    int         k;
    case (w.action)
      ACT_REFRESH: begin
        if (w.blink_event) blink_q = ~blink_q;
        if (!show_date) begin
          shown[0] = {1'b0, hour_q};
          shown[1] = minute_q;
          shown[2] = second_q;
        end else begin
          shown[0] = {1'b0, day_q};
          shown[1] = {2'b00, month_q};
          shown[2] = year_q;
        end
        for (k = 0; k < 3; k++) begin
          if (blink_q && sel_q == k[1:0]) begin
            exp_w[(5 - 2 * k) * 4 +: 4] = BLANK_CODE;
            exp_w[(4 - 2 * k) * 4 +: 4] = BLANK_CODE;
          end else begin
            exp_w[(5 - 2 * k) * 4 +: 4] = 4'(shown[k] / 10);
            exp_w[(4 - 2 * k) * 4 +: 4] = 4'(shown[k] % 10);
          end
        end
        digits_due.push_back(exp_w);
      end
      ACT_NEXT: sel_q = (sel_q == SEL_THIRD) ? SEL_FIRST : sel_q + 2'd1;
      ACT_DEC:  edit_selected(1'b0);
      ACT_INC:  edit_selected(1'b1);
      ACT_LOAD: begin
        hour_q   = w.load_hour;
        minute_q = w.load_minute;
        second_q = w.load_second;
        day_q    = w.load_day;
        month_q  = w.load_month;
        year_q   = w.load_year;
        sel_q    = SEL_FIRST;
        blink_q  = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_digits(input out_word_t got);
    out_word_t exp_w;
    int        k;
    if (digits_due.size() == 0) begin
      faults++;
      $display("%0t: unexpected output word %h, nothing expected", $time, got);
      return;
    end
    exp_w = digits_due.pop_front();
    for (k = 0; k < 6; k++) begin
      if (got[(5 - k) * 4 +: 4] !== exp_w[(5 - k) * 4 +: 4]) begin
        faults++;
        $display("%0t: digit_%0d expected %0d actual %0d", $time, k,
                 exp_w[(5 - k) * 4 +: 4], got[(5 - k) * 4 +: 4]);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      show_date = 1'b0;
      hour_q    = '0;
      minute_q  = '0;
      second_q  = '0;
      day_q     = 5'd1;
      month_q   = 4'd1;
      year_q    = '0;
      sel_q     = SEL_FIRST;
      blink_q   = 1'b0;
      digits_due.delete();
    end else begin
      if (out_valid && out_ready) check_digits(out_word);
      if (cfg_we) show_date = cfg_wdata;
      if (in_valid && in_ready) take_word(in_word);
    end
    fault_count <= faults;
    digits_owed <= digits_due.size();
  end

endmodule

/* dv/time_date_field_setter_tb.sv */
`timescale 1ns / 1ps
// Top of the time_date_field_setter testbench: clock, reset, stimulus and verdict.
// Depends on tdfs_pkg, the block under test and time_date_field_setter_checker.
module time_date_field_setter_tb;
  import tdfs_pkg::*;

  // Action codes the block must ignore.
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  localparam int PHASE_WORDS = 325;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_word;
  logic        cfg_we;
  logic        cfg_wdata;
  int unsigned fault_count;
  int unsigned digits_owed;

  // Pacing knobs for the sender and the receiver.
  bit fast_send;
  bit fast_drain;
  bit squeeze_req;

  time_date_field_setter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  time_date_field_setter_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fault_count (fault_count),
    .digits_owed (digits_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the run hangs.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic in_word_t make_word(input logic [2:0] act, input logic blink,
                                         input int h, input int m, input int s,
                                         input int d, input int mo, input int y);
    in_word_t w;
    w.action      = act;
    w.blink_event = blink;
    w.load_hour   = h[4:0];
    w.load_minute = m[5:0];
    w.load_second = s[5:0];
    w.load_day    = d[4:0];
    w.load_month  = mo[3:0];
    w.load_year   = y[5:0];
    return w;
  endfunction

  // Lean on the limits and the values just under them; now and then go past
  // the legal range to the full field width.
  function automatic int pick_value(input int lo, input int hi, input int width);
    case ($urandom_range(0, 9))
      0, 1:    return hi;
      2:       return lo;
      3:       return $urandom_range(0, (1 << width) - 1);
      4:       return hi - $urandom_range(0, 3);
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // Mostly edits and refreshes so the fields walk across their wrap points;
  // loads reseed near the limits, a few unused codes are mixed in as noise.
  function automatic in_word_t random_word();
    int         r;
    logic [2:0] act;
    r = $urandom_range(0, 99);
    if (r < 35)      act = ACT_REFRESH;
    else if (r < 50) act = ACT_NEXT;
    else if (r < 65) act = ACT_DEC;
    else if (r < 82) act = ACT_INC;
    else if (r < 95) act = ACT_LOAD;
    else             act = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    return make_word(act, 1'($urandom_range(0, 1)),
                     pick_value(0, 23, 5), pick_value(0, 59, 6), pick_value(0, 59, 6),
                     pick_value(1, 31, 5), pick_value(1, 12, 4), pick_value(0, 40, 6));
  endfunction

  // Offer one word and hold it until the block takes it. With no gap the
  // valid stays up from the previous word, so only the payload moves.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = fast_send ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drain the block: no word offered, every refresh answered, and a few more
  // cycles for an edit still sitting in the input register.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (digits_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_mode(input logic mode);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Receiver: stall a random number of cycles before each word, none while
  // fast_drain is set, and once hold off long enough to back up the input.
  initial begin
    int stall;
    bit squeeze_done;
    squeeze_done = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        stall = 60;
        squeeze_done = 1'b1;
      end else if (fast_drain) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 14);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int p;
    int n;
    fast_send   = 1'b0;
    fast_drain  = 1'b0;
    squeeze_req = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Time mode: reset values, hour wrap below zero and above 23, blink
    // toggling, minute wrap, a second decrement, selector wrap, out-of-range load
    // values that hold on increment and step down on decrement, unused codes.
    program_mode(1'b0);
    send_word(make_word(ACT_REFRESH, 1'b0, 0, 0, 0, 1, 1, 0));
    send_word(make_word(ACT_DEC, 1'b0, 0, 0, 0, 1, 1, 0));
    send_word(make_word(ACT_REFRESH, 1'b1, 0, 0, 0, 1, 1, 0));
    send_word(make_word(ACT_NEXT, 1'b0, 0, 0, 0, 1, 1, 0));
    send_word(make_word(ACT_LOAD, 1'b0, 23, 59, 59, 31, 12, 40));
    send_word(make_word(ACT_INC, 1'b1, 0, 0, 0, 1, 1, 0));
    send_word(make_word(ACT_NEXT, 1'b0, 0, 0, 0, 1, 1, 0));
    send_word(make_word(ACT_INC, 1'b0, 0, 0, 0, 1, 1, 0));
    send_word(make_word(ACT_NEXT, 1'b0, 0, 0, 0, 1, 1, 0));
    send_word(make_word(ACT_DEC, 1'b0, 0, 0, 0, 1, 1, 0));
    send_word(make_word(ACT_NEXT, 1'b0, 0, 0, 0, 1, 1, 0));
    send_word(make_word(ACT_REFRESH, 1'b1, 0, 0, 0, 1, 1, 0));
    send_word(make_word(ACT_LOAD, 1'b1, 31, 63, 63, 0, 0, 63));
    send_word(make_word(ACT_INC, 1'b0, 0, 0, 0, 1, 1, 0));
    send_word(make_word(ACT_DEC, 1'b0, 0, 0, 0, 1, 1, 0));
    send_word(make_word(ACT_UNUSED_LO, 1'b1, 0, 0, 0, 1, 1, 0));
    send_word(make_word(ACT_UNUSED_HI, 1'b0, 31, 63, 63, 31, 15, 63));
    send_word(make_word(ACT_REFRESH, 1'b0, 0, 0, 0, 1, 1, 0));

    // Date mode: leap February in year 0, common February, a day above the
    // month's limit, zero day at decrement and increment, zero month at decrement.
    program_mode(1'b1);
    send_word(make_word(ACT_LOAD, 1'b0, 0, 0, 0, 29, 2, 0));
    send_word(make_word(ACT_INC, 1'b0, 0, 0, 0, 1, 1, 0));
    send_word(make_word(ACT_LOAD, 1'b0, 0, 0, 0, 29, 2, 1));
    send_word(make_word(ACT_INC, 1'b0, 0, 0, 0, 1, 1, 0));
    send_word(make_word(ACT_LOAD, 1'b0, 0, 0, 0, 0, 0, 63));
    send_word(make_word(ACT_DEC, 1'b0, 0, 0, 0, 1, 1, 0));
    send_word(make_word(ACT_INC, 1'b0, 0, 0, 0, 1, 1, 0));
    send_word(make_word(ACT_NEXT, 1'b0, 0, 0, 0, 1, 1, 0));
    send_word(make_word(ACT_DEC, 1'b0, 0, 0, 0, 1, 1, 0));
    send_word(make_word(ACT_REFRESH, 1'b1, 0, 0, 0, 1, 1, 0));

    // Random phases, alternating the mode. Phase 2 runs both sides flat out;
    // phase 3 opens with a burst of refreshes while the receiver holds off.
    for (p = 0; p < 6; p++) begin
      program_mode(p[0]);
      fast_send  = (p == 2);
      fast_drain = (p == 2);
      if (p == 3) begin
        fast_send   = 1'b1;
        squeeze_req = 1'b1;
        for (n = 0; n < 16; n++) begin
          send_word(make_word(ACT_REFRESH, 1'($urandom_range(0, 1)), 0, 0, 0, 1, 1, 0));
        end
        fast_send = 1'b0;
      end
      for (n = 0; n < PHASE_WORDS; n++) begin
        send_word(random_word());
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
